// ===== rtl/vwbp_pkg.sv =====
package vwbp_pkg;

	localparam int BYTE_W = 8;
	localparam int VALUE_W = 31;
	localparam int COUNT_W = 5;
	localparam int FIELD_W_MAX = 6;
	localparam int LENGTH_FIELD_BITS_DEF = 5;
	localparam int QUEUE_DEPTH_DEF = 2;

	// value shifted so its leading one sits in the top bit, plus its bit count
	typedef struct packed {
		logic [VALUE_W-1:0] norm;
		logic [COUNT_W-1:0] count;
	} norm_t;

	// one classified value on its way from front to back
	typedef struct packed {
		logic [VALUE_W-1:0]     src;
		logic [COUNT_W-1:0]     count;
		logic [FIELD_W_MAX-1:0] field;
		logic                   last;
	} entry_t;

	// queue status seen by the back end
	typedef struct packed {
		logic empty;
		logic full;
	} queue_stat_t;

	// five-step leading-zero search that normalizes on the way
	function automatic norm_t normalize(input logic [VALUE_W-1:0] v);
		logic [31:0] x;
		logic [5:0]  lz;
		norm_t       r;
		x = {1'b0, v};
		lz = '0;
		if (x[31:16] == 16'd0) begin
			x = x << 16;
			lz = lz + 6'd16;
		end
		if (x[31:24] == 8'd0) begin
			x = x << 8;
			lz = lz + 6'd8;
		end
		if (x[31:28] == 4'd0) begin
			x = x << 4;
			lz = lz + 6'd4;
		end
		if (x[31:30] == 2'd0) begin
			x = x << 2;
			lz = lz + 6'd2;
		end
		if (x[31] == 1'b0) begin
			x = x << 1;
			lz = lz + 6'd1;
		end
		r.norm = x[31:1];
		r.count = (v == '0) ? '0 : COUNT_W'(6'd32 - lz);
		return r;
	endfunction

endpackage

// ===== rtl/variable_width_bit_packer.sv =====
// Variable width bit packer.
// Slave stream: s_tdata[30:0] carries a non-negative value, s_tlast marks the
// final value of a run. Master stream: one beat per output byte, m_tuser says
// which stream it belongs to (0 packed value bits, 1 length fields), m_tlast
// marks the last byte caused by one input value.
// The front end registers each value, finds its significant bit count with a
// five-step leading-zero search and saturates the length field; a short queue
// decouples it from the back end, which splices bits into the two byte
// accumulators and drives the output register.
// Each accepted value is registered in the front end and then pushed into
// the queue; the back end takes the entry, closes each completed value byte
// and absorbs the leftover value bits, flushes the value accumulator on a
// last value, adds the length field and, on a last value, flushes the length
// accumulator. It advances one step per cycle while the output register can
// take a byte; each byte enters the output register with the step that makes it.
// Reset empties the queue, the accumulators and the output register.
// A stalled receiver holds the output beat; the back end freezes, the queue
// fills and then s_tready drops.
module variable_width_bit_packer #(
	parameter int LENGTH_FIELD_BITS = vwbp_pkg::LENGTH_FIELD_BITS_DEF,
	parameter int QUEUE_DEPTH = vwbp_pkg::QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [30:0] value, [31] zero pad
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [7:0] data_byte
	output logic        m_tuser,   // [0] stream
	output logic        m_tlast
);

	logic                  push;
	logic                  pop;
	vwbp_pkg::entry_t      push_entry;
	vwbp_pkg::entry_t      head;
	vwbp_pkg::queue_stat_t stat;

	// front: take a value, count its bits, push the classified entry
	vwbp_front #(
		.LENGTH_FIELD_BITS(LENGTH_FIELD_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_value  (s_tdata[30:0]),
		.in_last   (s_tlast),
		.push      (push),
		.push_entry(push_entry),
		.queue_full(stat.full)
	);

	// queue: hold entries while the back end drains bytes
	vwbp_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_entry(push_entry),
		.pop       (pop),
		.head      (head),
		.stat      (stat)
	);

	// back: splice bits into bytes, flush on a last value
	vwbp_back #(
		.LENGTH_FIELD_BITS(LENGTH_FIELD_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.stat      (stat),
		.pop       (pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_byte  (m_tdata),
		.out_stream(m_tuser),
		.out_last  (m_tlast)
	);

	// never push into a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !stat.full)
		else $error("push into full queue");

	// never pop an empty queue
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !stat.empty)
		else $error("pop from empty queue");

	// an accepted beat reaches the queue or waits for it
	a_accept_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> (push || stat.full))
		else $error("accepted value lost in front end");

endmodule

// ===== rtl/vwbp_front.sv =====
module vwbp_front #(
	parameter int LENGTH_FIELD_BITS = vwbp_pkg::LENGTH_FIELD_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [vwbp_pkg::VALUE_W-1:0] in_value,
	input  logic                         in_last,
	output logic                         push,
	output vwbp_pkg::entry_t             push_entry,
	input  logic                         queue_full
);

	localparam logic [5:0] FIELD_MAX = 6'((1 << LENGTH_FIELD_BITS) - 1);

	logic                         valid_s1;
	logic [vwbp_pkg::VALUE_W-1:0] value_s1;
	logic                         last_s1;
	vwbp_pkg::norm_t              nrm;
	logic [5:0]                   count6;

	assign push = valid_s1 && !queue_full;
	assign in_ready = !valid_s1 || push;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			value_s1 <= in_value;
			last_s1 <= in_last;
		end
	end

	always_comb begin
		nrm = vwbp_pkg::normalize(value_s1);
		count6 = {1'b0, nrm.count};
		push_entry.src = nrm.norm;
		push_entry.count = nrm.count;
		// saturate the length field when the count does not fit
		push_entry.field = (count6 > FIELD_MAX) ? FIELD_MAX : count6;
		push_entry.last = last_s1;
	end

endmodule

// ===== rtl/vwbp_queue.sv =====
module vwbp_queue #(
	parameter int DEPTH = vwbp_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  vwbp_pkg::entry_t      push_entry,
	input  logic                  pop,
	output vwbp_pkg::entry_t      head,
	output vwbp_pkg::queue_stat_t stat
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	vwbp_pkg::entry_t mem [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	assign stat.empty = (cnt_q == '0);
	assign stat.full = (cnt_q == FULL_CNT);
	assign head = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

endmodule

// ===== rtl/vwbp_back.sv =====
module vwbp_back #(
	parameter int LENGTH_FIELD_BITS = vwbp_pkg::LENGTH_FIELD_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  vwbp_pkg::entry_t            head,
	input  vwbp_pkg::queue_stat_t       stat,
	output logic                        pop,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [vwbp_pkg::BYTE_W-1:0] out_byte,
	output logic                        out_stream,
	output logic                        out_last
);

	localparam int L = LENGTH_FIELD_BITS;
	localparam logic [3:0] L4 = 4'(L);

	typedef enum logic [4:0] {
		PH_IDLE = 5'b00001,
		PH_VAL  = 5'b00010,
		PH_VFL  = 5'b00100,
		PH_LEN  = 5'b01000,
		PH_LFL  = 5'b10000
	} phase_t;

	phase_t      phase_q, phase_n;
	logic [7:0]  vacc_q, vacc_n, lacc_q, lacc_n;
	logic [2:0]  vused_q, vused_n, lused_q, lused_n;
	logic [30:0] src_q, src_n;
	logic [4:0]  rem_q, rem_n;
	logic [vwbp_pkg::FIELD_W_MAX-1:0] field_q, field_n;
	logic        last_q, last_n;

	logic        out_valid_q, out_stream_q, out_last_q;
	logic [7:0]  out_byte_q;

	logic        adv, step, emit, emit_last, emit_stream;
	logic [7:0]  emit_byte;
	logic [15:0] win_v, win_l, sh_emit_v, sh_part_v, sh_emit_l;
	logic [5:0]  vsum;
	logic [3:0]  take, lsum;
	logic [4:0]  remn;
	logic [2:0]  lremn;
	logic        len_any;
	logic [7:0]  fld8, fld_top;

	assign out_valid = out_valid_q;
	assign out_byte = out_byte_q;
	assign out_stream = out_stream_q;
	assign out_last = out_last_q;

	always_comb begin
		adv = !out_valid_q || out_ready;
		fld8 = {{(8 - L){1'b0}}, field_q[L-1:0]};
		fld_top = {field_q[L-1:0], {(8 - L){1'b0}}};
		win_v = {vacc_q, src_q[30:23]};
		win_l = {lacc_q, fld_top};
		vsum = {3'b000, vused_q} + {1'b0, rem_q};
		take = 4'd8 - {1'b0, vused_q};
		remn = rem_q - {1'b0, take};
		lsum = {1'b0, lused_q} + L4;
		lremn = lsum[2:0];
		len_any = (lsum >= 4'd8) || (last_q && (lsum[2:0] != 3'd0));
		sh_emit_v = win_v >> vused_q;
		sh_part_v = win_v >> (4'd8 - rem_q[3:0]);
		sh_emit_l = win_l >> lused_q;

		phase_n = phase_q;
		vacc_n = vacc_q;
		vused_n = vused_q;
		lacc_n = lacc_q;
		lused_n = lused_q;
		src_n = src_q;
		rem_n = rem_q;
		field_n = field_q;
		last_n = last_q;
		pop = 1'b0;
		emit = 1'b0;
		emit_last = 1'b0;
		emit_stream = 1'b0;
		emit_byte = '0;

		unique case (phase_q)
			PH_IDLE: begin
				if (!stat.empty) begin
					pop = 1'b1;
					src_n = head.src;
					rem_n = head.count;
					field_n = head.field;
					last_n = head.last;
					phase_n = PH_VAL;
				end
			end
			PH_VAL: begin
				if (vsum >= 6'd8) begin
					// close the pending byte with the top bits of the value
					emit = 1'b1;
					emit_byte = sh_emit_v[7:0];
					emit_last = (remn < 5'd8) && !(last_q && remn != 5'd0) && !len_any;
					src_n = src_q << take;
					rem_n = remn;
					vacc_n = '0;
					vused_n = '0;
				end else begin
					vacc_n = sh_part_v[7:0];
					vused_n = vused_q + rem_q[2:0];
					phase_n = last_q ? PH_VFL : PH_LEN;
				end
			end
			PH_VFL: begin
				if (vused_q != 3'd0) begin
					emit = 1'b1;
					emit_byte = vacc_q << (4'd8 - {1'b0, vused_q});
					emit_last = !len_any;
				end
				vacc_n = '0;
				vused_n = '0;
				phase_n = PH_LEN;
			end
			PH_LEN: begin
				if (lsum >= 4'd8) begin
					emit = 1'b1;
					emit_stream = 1'b1;
					emit_byte = sh_emit_l[7:0];
					emit_last = !(last_q && lremn != 3'd0);
					lacc_n = fld8 & ((8'd1 << lremn) - 8'd1);
					lused_n = lremn;
				end else begin
					lacc_n = (lacc_q << L) | fld8;
					lused_n = lsum[2:0];
				end
				phase_n = last_q ? PH_LFL : PH_IDLE;
			end
			PH_LFL: begin
				if (lused_q != 3'd0) begin
					emit = 1'b1;
					emit_stream = 1'b1;
					emit_byte = lacc_q << (4'd8 - {1'b0, lused_q});
					emit_last = 1'b1;
				end
				lacc_n = '0;
				lused_n = '0;
				phase_n = PH_IDLE;
			end
			default: begin
				phase_n = PH_IDLE;
			end
		endcase

		step = !emit || adv;
		if (!step) begin
			pop = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			vacc_q <= '0;
			vused_q <= '0;
			lacc_q <= '0;
			lused_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (step) begin
				phase_q <= phase_n;
				vacc_q <= vacc_n;
				vused_q <= vused_n;
				lacc_q <= lacc_n;
				lused_q <= lused_n;
			end
			if (step && emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			src_q <= src_n;
			rem_q <= rem_n;
			field_q <= field_n;
			last_q <= last_n;
		end
		if (step && emit) begin
			out_byte_q <= emit_byte;
			out_stream_q <= emit_stream;
			out_last_q <= emit_last;
		end
	end

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

	localparam int VALUE_W     = vwbp_pkg::VALUE_W;
	localparam int BYTE_W      = vwbp_pkg::BYTE_W;
	localparam int FIELD_W_MAX = vwbp_pkg::FIELD_W_MAX;

	localparam int FIELD_BITS  = vwbp_pkg::LENGTH_FIELD_BITS_DEF;
	localparam int FIELD_MAX   = (1 << FIELD_BITS) - 1;
	localparam int STALL_LIMIT = 2000;
	localparam int TAIL_CYCLES = 32;

	localparam logic STREAM_VALUE  = 1'b0;
	localparam logic STREAM_LENGTH = 1'b1;

	typedef enum int {
		RDY_ALWAYS,
		RDY_LIGHT,
		RDY_HEAVY,
		RDY_PATTERN
	} ready_mode_t;

	// one value waiting to be offered; hold marks a pause until all bytes are out
	typedef struct {
		logic [VALUE_W-1:0] value;
		logic               last;
		bit                 hold;
	} value_item_t;

	typedef struct packed {
		logic       stream;
		logic [7:0] data_byte;
		logic       last;
	} byte_beat_t;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata  = '0;
	logic        s_tlast  = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;
	logic        m_tuser;
	logic        m_tlast;

	value_item_t value_q[$];
	byte_beat_t  packed_bytes_q[$];

	// bit accumulators of both streams, indexed by stream code
	logic [7:0] acc_bits[2];
	int         acc_used[2];

	int mismatch_count = 0;
	int idle_cycles = 0;
	int accepted_count = 0;
	int total_items = 0;

	variable_width_bit_packer #(
		.LENGTH_FIELD_BITS(FIELD_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	always #4 clk = ~clk;

	function automatic void shift_in_bit(input logic stream, input logic b);
		acc_bits[stream] = {acc_bits[stream][6:0], b};
		acc_used[stream]++;
		if (acc_used[stream] == BYTE_W) begin
			packed_bytes_q.push_back('{stream, acc_bits[stream], 1'b0});
			acc_bits[stream] = '0;
			acc_used[stream] = 0;
		end
	endfunction

	// left-align the partial byte and pad with zeros; an empty one yields nothing
	function automatic void flush_stream(input logic stream);
		if (acc_used[stream] != 0)
			packed_bytes_q.push_back('{stream, 8'(acc_bits[stream] << (BYTE_W - acc_used[stream])),
				1'b0});
		acc_bits[stream] = '0;
		acc_used[stream] = 0;
	endfunction

	function automatic void pack_value(input logic [VALUE_W-1:0] v, input logic last);
		int                     width;
		logic [FIELD_W_MAX-1:0] field;
		int                     first;
		int                     k;
		width = 0;
		for (k = 0; k < VALUE_W; k++)
			if (v[k])
				width = k + 1;
		field = (width > FIELD_MAX) ? FIELD_W_MAX'(FIELD_MAX) : FIELD_W_MAX'(width);
		first = packed_bytes_q.size();
		for (k = width; k > 0; k--)
			shift_in_bit(STREAM_VALUE, v[k-1]);
		if (last)
			flush_stream(STREAM_VALUE);
		for (k = FIELD_BITS; k > 0; k--)
			shift_in_bit(STREAM_LENGTH, field[k-1]);
		if (last)
			flush_stream(STREAM_LENGTH);
		if (packed_bytes_q.size() > first)
			packed_bytes_q[packed_bytes_q.size()-1].last = 1'b1;
	endfunction

	// mostly a random bit width with its leading one set, sometimes raw bits
	function automatic logic [VALUE_W-1:0] random_value();
		int unsigned w;
		logic [31:0] mask;
		w = $urandom_range(0, VALUE_W);
		mask = (32'd1 << w) - 32'd1;
		if ($urandom_range(0, 7) == 0)
			return VALUE_W'($urandom);
		if (w == 0)
			return '0;
		return VALUE_W'(($urandom & mask) | (32'd1 << (w - 1)));
	endfunction

	task automatic queue_value(input logic [VALUE_W-1:0] v, input logic last, input bit hold);
		value_q.push_back('{v, last, hold});
		total_items++;
	endtask

	// driver: bursts of beats with random gaps in between
	always @(posedge clk) begin : driver
		int          burst_left;
		int          gap_left;
		logic        next_valid;
		value_item_t it;
		if (arst_n) begin
			next_valid = s_tvalid;
			if (s_tvalid && s_tready) begin
				pack_value(s_tdata[VALUE_W-1:0], s_tlast);
				accepted_count++;
				next_valid = 1'b0;
			end
			if (!next_valid) begin
				if (gap_left > 0)
					gap_left--;
				else if (value_q.size() > 0 && !(value_q[0].hold && packed_bytes_q.size() != 0)) begin
					it = value_q.pop_front();
					s_tdata <= {1'b0, it.value};
					s_tlast <= it.last;
					next_valid = 1'b1;
					if (burst_left > 0)
						burst_left--;
					if (burst_left == 0) begin
						burst_left = $urandom_range(1, 20);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
					end
				end
			end
			s_tvalid <= next_valid;
		end
	end

	// monitor: check each output beat, count idle cycles, pattern the receiver stall
	always @(posedge clk) begin : monitor
		byte_beat_t  want;
		ready_mode_t mode;
		int          mode_left;
		logic [7:0]  rot;
		logic        rdy;
		if (!arst_n) begin
			mode = RDY_ALWAYS;
			mode_left = 0;
			rot = 8'b1100_1010;
		end else begin
			if (m_tvalid && m_tready) begin
				if (packed_bytes_q.size() == 0) begin
					mismatch_count++;
					$display("%0t: unexpected beat stream=%0d byte=%02h last=%0d", $time,
						m_tuser, m_tdata, m_tlast);
				end else begin
					want = packed_bytes_q.pop_front();
					if (m_tuser !== want.stream) begin
						mismatch_count++;
						$display("%0t: stream expected %0d actual %0d", $time, want.stream, m_tuser);
					end
					if (m_tdata !== want.data_byte) begin
						mismatch_count++;
						$display("%0t: data_byte expected %02h actual %02h", $time,
							want.data_byte, m_tdata);
					end
					if (m_tlast !== want.last) begin
						mismatch_count++;
						$display("%0t: last_result expected %0d actual %0d", $time, want.last, m_tlast);
					end
				end
			end
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (mode_left == 0) begin
				mode = ready_mode_t'($urandom_range(0, 3));
				mode_left = $urandom_range(10, 80);
			end else begin
				mode_left--;
			end
			case (mode)
				RDY_ALWAYS: rdy = 1'b1;
				RDY_LIGHT:  rdy = ($urandom_range(0, 3) != 0);
				RDY_HEAVY:  rdy = ($urandom_range(0, 7) == 0);
				default: begin
					rdy = rot[0];
					rot = {rot[0], rot[7:1]};
				end
			endcase
			m_tready <= rdy;
		end
	end

	initial begin : stimulus
		int produced;
		int run_len;
		int k;
		bit timed_out;
		acc_bits[0] = '0;
		acc_bits[1] = '0;
		acc_used[0] = 0;
		acc_used[1] = 0;

		// zero value alone: no result, then two length bytes with an empty value flush
		queue_value('0, 1'b0, 1'b0);
		queue_value('0, 1'b1, 1'b0);
		queue_value(31'h7FFF_FFFF, 1'b0, 1'b0);
		queue_value(31'h0000_0001, 1'b0, 1'b0);
		queue_value(31'h7FFF_FFFF, 1'b1, 1'b0);
		// eight 8-bit values: both streams byte aligned at the flush
		for (k = 0; k < 8; k++)
			queue_value(31'h0000_00FF, (k == 7), (k == 0));
		queue_value(31'h4000_0000, 1'b1, 1'b0);
		queue_value(31'h2AAA_AAAA, 1'b0, 1'b0);
		queue_value(31'h5555_5555, 1'b1, 1'b0);
		queue_value(31'h0000_0001, 1'b1, 1'b0);
		queue_value(31'h0000_8000, 1'b0, 1'b0);
		queue_value(31'h0080_0000, 1'b1, 1'b0);

		// runs of random values closed by a last, some with an early last inside
		produced = 0;
		while (produced < 330) begin
			run_len = ($urandom_range(0, 5) == 0) ? $urandom_range(13, 30) : $urandom_range(1, 10);
			for (k = 0; k < run_len; k++)
				queue_value(random_value(),
					(k == run_len - 1) || ($urandom_range(0, 19) == 0),
					(k == 0) && (produced == 0 || $urandom_range(0, 24) == 0));
			produced += run_len;
		end

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		timed_out = 1'b0;
		while (!timed_out && !(accepted_count == total_items && packed_bytes_q.size() == 0)) begin
			@(negedge clk);
			if (idle_cycles >= STALL_LIMIT)
				timed_out = 1'b1;
		end
		if (!timed_out)
			repeat (TAIL_CYCLES) @(negedge clk);
		if (packed_bytes_q.size() != 0) begin
			mismatch_count++;
			$display("%0t: %0d expected beats never arrived", $time, packed_bytes_q.size());
		end
		if (!timed_out && mismatch_count == 0)
			$display("variable_width_bit_packer regression: pass");
		else
			$display("variable_width_bit_packer regression: fail");
		$finish;
	end

endmodule
